>>> sv/htsu_pkg.sv
// Shared constants, codes and types for the hyperplane translation score unit.
`default_nettype none

package htsu_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int DIM_DEF     = 64;
    localparam int NUM_ENT_DEF = 4096;
    localparam int NUM_REL_DEF = 256;

    // Fixed field widths.
    localparam int OP_W      = 2;
    localparam int VAL_W     = 16;
    localparam int ENT_IN_W  = 12;
    localparam int REL_IN_W  = 8;
    localparam int ELEM_IN_W = 6;
    localparam int ENERGY_W  = 31;

    // Reciprocal shifts for index wrap: twice the input index width keeps
    // the multiply-by-reciprocal quotient exact for any divisor below 2^width.
    localparam int ENT_RSHIFT = 2 * ENT_IN_W;
    localparam int REL_RSHIFT = 2 * REL_IN_W;

    // Fixed point: products are Q.24, per-element terms Q.36, energy Q.12.
    localparam int FRAC_SHIFT = 24;
    localparam int ROUND_HALF = 1 << (FRAC_SHIFT - 1);

    typedef enum logic [OP_W-1:0] {
        OP_ENT_WR = 2'd0,
        OP_REL_WR = 2'd1,
        OP_NRM_WR = 2'd2,
        OP_SCORE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RED1,
        ST_RED2,
        ST_ENT_WR,
        ST_RN_RD,
        ST_RN_WR,
        ST_DOT,
        ST_DOT_WAIT,
        ST_L1,
        ST_L1_WAIT
    } t_state;

    // Sequencer to datapath, aligned with the RAM read data.
    typedef struct packed {
        logic dot_vld;
        logic l1_vld;
        logic first;
        logic last;
    } t_dp_ctl;

    // Datapath back to sequencer.
    typedef struct packed {
        logic dot_done;
        logic l1_done;
    } t_dp_sts;

    // Index width for a count of n (at least one bit).
    function automatic int idx_w(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

`default_nettype wire

>>> sv/htsu_ram.sv
// Generic synchronous RAM: one write port, one or two registered read ports.
`default_nettype none

module htsu_ram #(
    parameter int W        = htsu_pkg::VAL_W,
    parameter int DEPTH    = 2,
    parameter int RD_PORTS = 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [htsu_pkg::idx_w(DEPTH)-1:0]   i_waddr,
    input  wire logic [W-1:0]                        i_wdata,
    input  wire logic [htsu_pkg::idx_w(DEPTH)-1:0]   i_raddr_a,
    output logic      [W-1:0]                        o_rdata_a,
    input  wire logic [htsu_pkg::idx_w(DEPTH)-1:0]   i_raddr_b,
    output logic      [W-1:0]                        o_rdata_b
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata_a;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
    end

    assign o_rdata_a = r_rdata_a;

    generate
        if (RD_PORTS > 1) begin : g_rd_b
            logic [W-1:0] r_rdata_b;
            always_ff @(posedge i_clk) begin
                r_rdata_b <= r_mem[i_raddr_b];
            end
            assign o_rdata_b = r_rdata_b;
        end else begin : g_no_rd_b
            assign o_rdata_b = '0;
        end
    endgenerate

endmodule

`default_nettype wire

>>> sv/htsu_ctrl.sv
// Sequencer: word capture, index wrap, table writes and score read walks.
`default_nettype none

module htsu_ctrl #(
    parameter int DIM           = htsu_pkg::DIM_DEF,
    parameter int NUM_ENTITIES  = htsu_pkg::NUM_ENT_DEF,
    parameter int NUM_RELATIONS = htsu_pkg::NUM_REL_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic [htsu_pkg::OP_W-1:0]         i_op,
    input  wire logic [htsu_pkg::ENT_IN_W-1:0]     i_head,
    input  wire logic [htsu_pkg::ENT_IN_W-1:0]     i_tail,
    input  wire logic [htsu_pkg::REL_IN_W-1:0]     i_rel,
    input  wire logic [htsu_pkg::ELEM_IN_W-1:0]    i_elem,
    input  wire logic [htsu_pkg::VAL_W-1:0]        i_val,
    output logic                                   o_ent_we,
    output logic [htsu_pkg::idx_w(NUM_ENTITIES)+htsu_pkg::idx_w(DIM)-1:0]  o_ent_waddr,
    output logic [htsu_pkg::VAL_W-1:0]             o_ent_wdata,
    output logic [htsu_pkg::idx_w(NUM_ENTITIES)+htsu_pkg::idx_w(DIM)-1:0]  o_ent_raddr_a,
    output logic [htsu_pkg::idx_w(NUM_ENTITIES)+htsu_pkg::idx_w(DIM)-1:0]  o_ent_raddr_b,
    output logic                                   o_rn_we,
    output logic [htsu_pkg::idx_w(NUM_RELATIONS)+htsu_pkg::idx_w(DIM)-1:0] o_rn_waddr,
    output logic [2*htsu_pkg::VAL_W-1:0]           o_rn_wdata,
    output logic [htsu_pkg::idx_w(NUM_RELATIONS)+htsu_pkg::idx_w(DIM)-1:0] o_rn_raddr,
    input  wire logic [2*htsu_pkg::VAL_W-1:0]      i_rn_rdata,
    output htsu_pkg::t_dp_ctl                      o_dp_ctl,
    input  wire htsu_pkg::t_dp_sts                 i_dp_sts
);

    localparam int VW  = htsu_pkg::VAL_W;
    localparam int EIW = htsu_pkg::ENT_IN_W;
    localparam int RIW = htsu_pkg::REL_IN_W;
    localparam int DW  = htsu_pkg::idx_w(DIM);
    localparam int EW  = htsu_pkg::idx_w(NUM_ENTITIES);
    localparam int RW  = htsu_pkg::idx_w(NUM_RELATIONS);
    localparam int ES  = htsu_pkg::ENT_RSHIFT;
    localparam int RS  = htsu_pkg::REL_RSHIFT;
    localparam int EPW = EIW + ES + 1;
    localparam int RPW = RIW + RS + 1;

    // Wrap needed only when the count is below the index range.
    localparam bit ENT_WRAP = (NUM_ENTITIES < (1 << EIW));
    localparam bit REL_WRAP = (NUM_RELATIONS < (1 << RIW));
    localparam logic [ES:0] ENT_RECIP = (ES + 1)'(((1 << ES) + NUM_ENTITIES - 1) / NUM_ENTITIES);
    localparam logic [RS:0] REL_RECIP = (RS + 1)'(((1 << RS) + NUM_RELATIONS - 1) / NUM_RELATIONS);

    htsu_pkg::t_state  r_state, n_state;
    logic [DW-1:0]     r_elem, n_elem;
    htsu_pkg::t_dp_ctl r_ctl, n_ctl;

    htsu_pkg::t_op     r_op;
    logic [EIW-1:0]    r_head, r_tail, r_qh, r_qt;
    logic [RIW-1:0]    r_rel, r_qr;
    logic [htsu_pkg::ELEM_IN_W-1:0] r_ei;
    logic [VW-1:0]     r_val;
    logic [EW-1:0]     r_hidx, r_tidx;
    logic [RW-1:0]     r_ridx;

    logic [EPW-1:0]    prod_h, prod_t, rem_h, rem_t;
    logic [RPW-1:0]    prod_r, rem_r;
    logic [DW-1:0]     ei_dw;
    logic              elem_ok, elem_first, elem_last;

    // Quotient by reciprocal multiply, then remainder by multiply-subtract.
    assign prod_h = EPW'(r_head) * EPW'(ENT_RECIP);
    assign prod_t = EPW'(r_tail) * EPW'(ENT_RECIP);
    assign prod_r = RPW'(r_rel) * RPW'(REL_RECIP);
    assign rem_h  = EPW'(r_head) - EPW'(r_qh) * EPW'(NUM_ENTITIES);
    assign rem_t  = EPW'(r_tail) - EPW'(r_qt) * EPW'(NUM_ENTITIES);
    assign rem_r  = RPW'(r_rel) - RPW'(r_qr) * RPW'(NUM_RELATIONS);

    assign ei_dw      = DW'(r_ei);
    assign elem_ok    = (32'(r_ei) < DIM);
    assign elem_first = (r_elem == '0);
    assign elem_last  = (r_elem == DW'(DIM - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htsu_pkg::ST_IDLE;
            r_elem  <= '0;
            r_ctl   <= '0;
        end else begin
            r_state <= n_state;
            r_elem  <= n_elem;
            r_ctl   <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_op   <= htsu_pkg::t_op'(i_op);
            r_head <= i_head;
            r_tail <= i_tail;
            r_rel  <= i_rel;
            r_ei   <= i_elem;
            r_val  <= i_val;
        end
        if (r_state == htsu_pkg::ST_RED1) begin
            r_qh <= prod_h[ES +: EIW];
            r_qt <= prod_t[ES +: EIW];
            r_qr <= prod_r[RS +: RIW];
        end
        if (r_state == htsu_pkg::ST_RED2) begin
            r_hidx <= ENT_WRAP ? EW'(rem_h[EIW-1:0]) : EW'(r_head);
            r_tidx <= ENT_WRAP ? EW'(rem_t[EIW-1:0]) : EW'(r_tail);
            r_ridx <= REL_WRAP ? RW'(rem_r[RIW-1:0]) : RW'(r_rel);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_elem     = r_elem;
        n_ctl      = '0;
        o_ent_we   = 1'b0;
        o_rn_we    = 1'b0;
        o_rn_raddr = {r_ridx, r_elem};
        case (r_state)
            htsu_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = htsu_pkg::ST_RED1;
                end
            end
            htsu_pkg::ST_RED1: begin
                n_state = htsu_pkg::ST_RED2;
            end
            htsu_pkg::ST_RED2: begin
                n_elem = '0;
                case (r_op)
                    htsu_pkg::OP_ENT_WR: begin
                        n_state = elem_ok ? htsu_pkg::ST_ENT_WR : htsu_pkg::ST_IDLE;
                    end
                    htsu_pkg::OP_REL_WR, htsu_pkg::OP_NRM_WR: begin
                        n_state = elem_ok ? htsu_pkg::ST_RN_RD : htsu_pkg::ST_IDLE;
                    end
                    htsu_pkg::OP_SCORE: begin
                        n_state = htsu_pkg::ST_DOT;
                    end
                    default: begin
                        n_state = htsu_pkg::ST_IDLE;
                    end
                endcase
            end
            htsu_pkg::ST_ENT_WR: begin
                o_ent_we = 1'b1;
                n_state  = htsu_pkg::ST_IDLE;
            end
            htsu_pkg::ST_RN_RD: begin
                // fetch the shared word; the other half is kept on write-back
                o_rn_raddr = {r_ridx, ei_dw};
                n_state    = htsu_pkg::ST_RN_WR;
            end
            htsu_pkg::ST_RN_WR: begin
                o_rn_we = 1'b1;
                n_state = htsu_pkg::ST_IDLE;
            end
            htsu_pkg::ST_DOT: begin
                n_ctl.dot_vld = 1'b1;
                n_ctl.first   = elem_first;
                n_ctl.last    = elem_last;
                if (elem_last) begin
                    n_elem  = '0;
                    n_state = htsu_pkg::ST_DOT_WAIT;
                end else begin
                    n_elem = r_elem + 1'b1;
                end
            end
            htsu_pkg::ST_DOT_WAIT: begin
                if (i_dp_sts.dot_done) begin
                    n_state = htsu_pkg::ST_L1;
                end
            end
            htsu_pkg::ST_L1: begin
                n_ctl.l1_vld = 1'b1;
                n_ctl.first  = elem_first;
                n_ctl.last   = elem_last;
                if (elem_last) begin
                    n_elem  = '0;
                    n_state = htsu_pkg::ST_L1_WAIT;
                end else begin
                    n_elem = r_elem + 1'b1;
                end
            end
            htsu_pkg::ST_L1_WAIT: begin
                if (i_dp_sts.l1_done) begin
                    n_state = htsu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = htsu_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy        = (r_state != htsu_pkg::ST_IDLE);
    assign o_ent_waddr   = {r_hidx, ei_dw};
    assign o_ent_wdata   = r_val;
    assign o_ent_raddr_a = {r_hidx, r_elem};
    assign o_ent_raddr_b = {r_tidx, r_elem};
    assign o_rn_waddr    = {r_ridx, ei_dw};
    // word layout: relation element high, normal element low
    assign o_rn_wdata    = (r_op == htsu_pkg::OP_REL_WR) ? {r_val, i_rn_rdata[VW-1:0]}
                                                         : {i_rn_rdata[2*VW-1:VW], r_val};
    assign o_dp_ctl      = r_ctl;

endmodule

`default_nettype wire

>>> sv/htsu_dp.sv
// Score datapath: projected dot product pass, then per-element L1 pass.
`default_nettype none

module htsu_dp #(
    parameter int DIM = htsu_pkg::DIM_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire htsu_pkg::t_dp_ctl                   i_ctl,
    input  wire logic signed [htsu_pkg::VAL_W-1:0]   i_h,
    input  wire logic signed [htsu_pkg::VAL_W-1:0]   i_t,
    input  wire logic [2*htsu_pkg::VAL_W-1:0]        i_rn,
    output htsu_pkg::t_dp_sts                        o_sts,
    output logic                                     o_valid,
    output logic [htsu_pkg::ENERGY_W-1:0]            o_energy
);

    localparam int VW     = htsu_pkg::VAL_W;
    localparam int FS     = htsu_pkg::FRAC_SHIFT;
    localparam int EGW    = htsu_pkg::ENERGY_W;
    localparam int DIFF_W = VW + 1;
    localparam int PROD_W = DIFF_W + VW;
    localparam int DOT_W  = PROD_W + 1 + $clog2(DIM);
    localparam int DH_W   = DOT_W - FS;
    localparam int PHI_W  = DH_W + VW;
    localparam int PLO_W  = FS + 1 + VW;
    localparam int LIN_W  = VW + 2;
    localparam int X_W    = PHI_W + 1;
    localparam int D_W    = X_W + FS + 1;
    localparam int MAG_W  = D_W + 1 - FS;
    localparam int L1_RAW = MAG_W + $clog2(DIM) + 1;
    localparam int L1_W   = (L1_RAW > EGW + 1) ? L1_RAW : EGW + 1;

    logic signed [VW-1:0]     rel_c, w_c;
    logic signed [DIFF_W-1:0] diff_c;
    logic signed [DH_W-1:0]   dh_c;
    logic signed [FS:0]       dl_c;
    logic signed [LIN_W-1:0]  lin_c;
    logic signed [X_W-1:0]    x_c;
    logic signed [D_W-1:0]    d_c;
    logic [D_W:0]             rnd_c;
    logic [L1_W-1:0]          sum_c;

    // dot pass
    logic                     r_pv, r_pfirst, r_plast;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DOT_W-1:0]  r_dot;
    // L1 pass stages
    logic                     r_v1, r_f1, r_last1;
    logic signed [LIN_W-1:0]  r_lin;
    logic signed [PHI_W-1:0]  r_phi;
    logic signed [PLO_W-1:0]  r_plo;
    logic                     r_v2, r_f2, r_last2;
    logic signed [D_W-1:0]    r_d;
    logic                     r_v3, r_f3, r_last3;
    logic [MAG_W-1:0]         r_mag;
    logic [L1_W-1:0]          r_l1;
    logic                     r_valid;
    logic [EGW-1:0]           r_energy;

    assign rel_c  = $signed(i_rn[2*VW-1:VW]);
    assign w_c    = $signed(i_rn[VW-1:0]);
    assign diff_c = DIFF_W'(i_t) - DIFF_W'(i_h);

    // w.(t-h) split at the binary point so each product stays narrow
    assign dh_c   = $signed(r_dot[DOT_W-1:FS]);
    assign dl_c   = $signed({1'b0, r_dot[FS-1:0]});
    assign lin_c  = LIN_W'(i_t) - LIN_W'(i_h) - LIN_W'(rel_c);

    assign x_c    = X_W'(r_lin) - X_W'(r_phi);
    assign d_c    = (D_W'(x_c) <<< FS) - D_W'(r_plo);

    // |d| rounded half up: negative side uses ~d = |d|-1
    assign rnd_c  = r_d[D_W-1] ? ({1'b0, ~r_d} + (D_W + 1)'(htsu_pkg::ROUND_HALF + 1))
                               : ({1'b0, r_d} + (D_W + 1)'(htsu_pkg::ROUND_HALF));

    assign sum_c  = (r_f3 ? '0 : r_l1) + L1_W'(r_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_pv    <= i_ctl.dot_vld;
            r_v1    <= i_ctl.l1_vld;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_valid <= r_v3 && r_last3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pfirst <= i_ctl.first;
        r_plast  <= i_ctl.last;
        r_prod   <= PROD_W'(diff_c) * PROD_W'(w_c);
        if (r_pv) begin
            r_dot <= (r_pfirst ? '0 : r_dot) + DOT_W'(r_prod);
        end

        r_f1    <= i_ctl.first;
        r_last1 <= i_ctl.last;
        r_lin   <= lin_c;
        r_phi   <= PHI_W'(dh_c) * PHI_W'(w_c);
        r_plo   <= PLO_W'(dl_c) * PLO_W'(w_c);

        r_f2    <= r_f1;
        r_last2 <= r_last1;
        r_d     <= d_c;

        r_f3    <= r_f2;
        r_last3 <= r_last2;
        r_mag   <= rnd_c[D_W:FS];

        if (r_v3) begin
            r_l1 <= sum_c;
        end
        if (r_v3 && r_last3) begin
            r_energy <= (|sum_c[L1_W-1:EGW]) ? {EGW{1'b1}} : sum_c[EGW-1:0];
        end
    end

    assign o_sts.dot_done = r_pv && r_plast;
    assign o_sts.l1_done  = r_v3 && r_last3;
    assign o_valid        = r_valid;
    assign o_energy       = r_energy;

endmodule

`default_nettype wire

>>> sv/hyperplane_translation_score_unit.sv
// Top level of the hyperplane translation score unit: tables, sequencer, datapath.
// Score: busy for two DIM-element passes over the RAMs plus pipeline drain; energy strobed
//   in the first cycle with busy low, the cycle in which the next start can be taken.
// Writes: entity wrap, write; relation/normal wrap, read-modify-write; element >= DIM no write.
// Reset (synchronous, active low) clears sequencer and strobes; tables are not cleared and
//   read undefined until written. The receiver cannot stall the result.
`default_nettype none

module hyperplane_translation_score_unit #(
    parameter int DIM           = htsu_pkg::DIM_DEF,
    parameter int NUM_ENTITIES  = htsu_pkg::NUM_ENT_DEF,
    parameter int NUM_RELATIONS = htsu_pkg::NUM_REL_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic [htsu_pkg::OP_W-1:0]             i_op,
    input  wire logic [htsu_pkg::ENT_IN_W-1:0]         i_head_index,
    input  wire logic [htsu_pkg::ENT_IN_W-1:0]         i_tail_index,
    input  wire logic [htsu_pkg::REL_IN_W-1:0]         i_relation_index,
    input  wire logic [htsu_pkg::ELEM_IN_W-1:0]        i_element_index,
    input  wire logic signed [htsu_pkg::VAL_W-1:0]     i_element_value,
    output logic                                       o_valid,
    output logic [htsu_pkg::ENERGY_W-1:0]              o_energy
);

    localparam int VW  = htsu_pkg::VAL_W;
    localparam int DW  = htsu_pkg::idx_w(DIM);
    localparam int EW  = htsu_pkg::idx_w(NUM_ENTITIES);
    localparam int RW  = htsu_pkg::idx_w(NUM_RELATIONS);
    // Tables are addressed as {row, element}; depth rounds up to a power of two.
    localparam int ENT_DEPTH = 1 << (EW + DW);
    localparam int RN_DEPTH  = 1 << (RW + DW);

    logic                  ent_we;
    logic [EW+DW-1:0]      ent_waddr, ent_raddr_a, ent_raddr_b;
    logic [VW-1:0]         ent_wdata, ent_rdata_a, ent_rdata_b;
    logic                  rn_we;
    logic [RW+DW-1:0]      rn_waddr, rn_raddr;
    logic [2*VW-1:0]       rn_wdata, rn_rdata;
    htsu_pkg::t_dp_ctl     dp_ctl;
    htsu_pkg::t_dp_sts     dp_sts;

    // Sequencer: wraps indices, runs writes and the two score passes.
    htsu_ctrl #(
        .DIM           (DIM),
        .NUM_ENTITIES  (NUM_ENTITIES),
        .NUM_RELATIONS (NUM_RELATIONS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_op          (i_op),
        .i_head        (i_head_index),
        .i_tail        (i_tail_index),
        .i_rel         (i_relation_index),
        .i_elem        (i_element_index),
        .i_val         (i_element_value),
        .o_ent_we      (ent_we),
        .o_ent_waddr   (ent_waddr),
        .o_ent_wdata   (ent_wdata),
        .o_ent_raddr_a (ent_raddr_a),
        .o_ent_raddr_b (ent_raddr_b),
        .o_rn_we       (rn_we),
        .o_rn_waddr    (rn_waddr),
        .o_rn_wdata    (rn_wdata),
        .o_rn_raddr    (rn_raddr),
        .i_rn_rdata    (rn_rdata),
        .o_dp_ctl      (dp_ctl),
        .i_dp_sts      (dp_sts)
    );

    // Entity table: head on port A, tail on port B, same element each cycle.
    htsu_ram #(
        .W        (VW),
        .DEPTH    (ENT_DEPTH),
        .RD_PORTS (2)
    ) u_ent_ram (
        .i_clk     (i_clk),
        .i_we      (ent_we),
        .i_waddr   (ent_waddr),
        .i_wdata   (ent_wdata),
        .i_raddr_a (ent_raddr_a),
        .o_rdata_a (ent_rdata_a),
        .i_raddr_b (ent_raddr_b),
        .o_rdata_b (ent_rdata_b)
    );

    // Relation vector and hyperplane normal share one word per element, so a
    // write of either half is a read-modify-write; busy keeps it from overlapping.
    htsu_ram #(
        .W        (2 * VW),
        .DEPTH    (RN_DEPTH),
        .RD_PORTS (1)
    ) u_rn_ram (
        .i_clk     (i_clk),
        .i_we      (rn_we),
        .i_waddr   (rn_waddr),
        .i_wdata   (rn_wdata),
        .i_raddr_a (rn_raddr),
        .o_rdata_a (rn_rdata),
        .i_raddr_b ('0),
        .o_rdata_b ()
    );

    // Pass 1 accumulates w.(t-h); pass 2 forms each projected difference,
    // rounds its magnitude to Q.12 and sums with saturation at the end.
    htsu_dp #(
        .DIM (DIM)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (dp_ctl),
        .i_h      (ent_rdata_a),
        .i_t      (ent_rdata_b),
        .i_rn     (rn_rdata),
        .o_sts    (dp_sts),
        .o_valid  (o_valid),
        .o_energy (o_energy)
    );

endmodule

`default_nettype wire

>>> sv/htsu_chk.sv
// Port-level checks for the score unit, bound to the top level.
`default_nettype none

module htsu_chk (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic o_valid
);

    // busy is raised in the cycle after a word is accepted
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted word");

    // the energy comes out only once the unit has gone idle
    a_result_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // a result follows a busy period
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result strobe without preceding work");

    // one score gives one strobe
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

endmodule

bind hyperplane_translation_score_unit htsu_chk u_htsu_chk (.*);

`default_nettype wire
